/* src/fcb_pkg.sv */
// Shared types, constants and the rounded fixed-point multiply for the
// fade curve Bezier point unit. No dependencies.
package fcb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = FRAC_BITS + 1;  // width of a Q1.F value, 0..ONE
    localparam int MW        = W + 2;          // width that holds up to 3*ONE

    typedef logic [W-1:0]  q_t;
    typedef logic [MW-1:0] qw_t;

    localparam q_t  ONE  = q_t'(1) << FRAC_BITS;
    localparam qw_t HALF = qw_t'(1) << (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        REG_BEND     = 2'd0,
        REG_STRENGTH = 2'd1,
        REG_MODE     = 2'd2,
        REG_FADE_OUT = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_BENDED  = 2'd0,
        MODE_S_SHAPE = 2'd1,
        MODE_LONG    = 2'd2
    } curve_mode_t;

    // Current configuration as held by the register file.
    typedef struct packed {
        q_t          bend;
        q_t          strength;
        curve_mode_t mode;
        logic        fade_out;
    } cfg_t;

    // Inner control points of the curve.
    typedef struct packed {
        q_t p1x;
        q_t p1y;
        q_t p2x;
        q_t p2y;
    } cpoints_t;

    // Basis weights of one request.
    typedef struct packed {
        qw_t w1;
        qw_t w2;
        q_t  w3;
    } weights_t;

    // Product reduced with round half up: (a*b + 2^(F-1)) >> F.
    function automatic qw_t qmul(input qw_t a, input qw_t b);
        logic [2*MW-1:0] prod;
        prod = ({{MW{1'b0}}, a} * {{MW{1'b0}}, b}) + {{MW{1'b0}}, HALF};
        return prod[FRAC_BITS +: MW];
    endfunction

endpackage

/* src/fcb_in_if.sv */
// Input channel of the fade curve Bezier point unit: one curve parameter.
// Depends on fcb_pkg.
interface fcb_in_if import fcb_pkg::*; ();
    logic valid;
    logic ready;
    q_t   t_param;

    modport source (output valid, output t_param, input ready);
    modport sink   (input valid, input t_param, output ready);
endinterface

/* src/fcb_out_if.sv */
// Output channel of the fade curve Bezier point unit: one curve point.
// Depends on fcb_pkg.
interface fcb_out_if import fcb_pkg::*; ();
    logic valid;
    logic ready;
    q_t   point_x;
    q_t   point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

/* src/fcb_weights.sv */
// Two pipeline stages that turn the curve parameter into the Bernstein weights.
// Depends on fcb_pkg and fcb_in_if.
module fcb_weights import fcb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    fcb_in_if.sink   param,
    output logic     wt_valid,
    input  logic     wt_ready,
    output weights_t wt
);

    logic a_valid_reg, a_valid_next;
    q_t   a_t_reg, a_u_reg, a_tu_reg, a_tt_reg;
    logic b_valid_reg, b_valid_next;
    weights_t b_wt_reg;

    logic en_a, en_b;
    q_t   t_sat, u_val;
    qw_t  w1_half, w2_half;

    assign en_b        = !b_valid_reg || wt_ready;
    assign en_a        = !a_valid_reg || en_b;
    assign param.ready = en_a;

    assign t_sat = (param.t_param > ONE) ? ONE : param.t_param;
    assign u_val = ONE - t_sat;

    assign a_valid_next = en_a ? param.valid : a_valid_reg;
    assign b_valid_next = en_b ? a_valid_reg : b_valid_reg;

    always_comb
    begin
        w1_half = qmul({2'b00, a_tu_reg}, {2'b00, a_u_reg});
        w2_half = qmul({2'b00, a_tu_reg}, {2'b00, a_t_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_t_reg  <= t_sat;
            a_u_reg  <= u_val;
            a_tu_reg <= q_t'(qmul({2'b00, t_sat}, {2'b00, u_val}));
            a_tt_reg <= q_t'(qmul({2'b00, t_sat}, {2'b00, t_sat}));
        end
        if (en_b)
        begin
            b_wt_reg.w1 <= (w1_half << 1) + w1_half;
            b_wt_reg.w2 <= (w2_half << 1) + w2_half;
            b_wt_reg.w3 <= q_t'(qmul({2'b00, a_tt_reg}, {2'b00, a_t_reg}));
        end
    end

    assign wt_valid = b_valid_reg;
    assign wt       = b_wt_reg;

endmodule

/* src/fcb_ctrl_points.sv */
// Derives the two inner control points from the configuration registers.
// Depends on fcb_pkg.
module fcb_ctrl_points import fcb_pkg::*;
(
    input  logic     clk,
    input  cfg_t     cfg,
    output cpoints_t cp
);

    q_t sb_reg, snb_reg;

    // Products follow the configuration in the next cycle. The user must
    // change configuration only while the pipeline is empty; not enforced.
    always_ff @(posedge clk)
    begin
        sb_reg  <= q_t'(qmul({2'b00, cfg.strength}, {2'b00, cfg.bend}));
        snb_reg <= q_t'(qmul({2'b00, cfg.strength}, {2'b00, q_t'(ONE - cfg.bend)}));
    end

    always_comb
    begin
        cp.p1x = snb_reg;
        cp.p1y = sb_reg;
        cp.p2x = ONE - snb_reg;
        cp.p2y = ONE - sb_reg;
        case (cfg.mode)
            MODE_BENDED:
            begin
                if (cfg.fade_out)
                begin
                    cp.p1x = sb_reg;
                    cp.p1y = snb_reg;
                end
                else
                begin
                    cp.p2x = ONE - sb_reg;
                    cp.p2y = ONE - snb_reg;
                end
            end
            MODE_S_SHAPE:
            begin
                cp.p1x = snb_reg;
            end
            default:
            begin
                if (cfg.fade_out)
                begin
                    cp.p1x = '0;
                    cp.p1y = '0;
                end
                else
                begin
                    cp.p2x = ONE;
                    cp.p2y = ONE;
                end
            end
        endcase
    end

endmodule

/* src/fcb_blend.sv */
// Two pipeline stages that weight the control points, sum, saturate and mirror.
// Depends on fcb_pkg and fcb_out_if.
module fcb_blend import fcb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wt_valid,
    output logic      wt_ready,
    input  weights_t  wt,
    input  cpoints_t  cp,
    input  logic      fade_out,
    fcb_out_if.source point
);

    logic c_valid_reg, c_valid_next;
    qw_t  c_x1_reg, c_x2_reg, c_y1_reg, c_y2_reg;
    q_t   c_w3_reg;
    logic d_valid_reg, d_valid_next;
    q_t   d_x_reg, d_y_reg;

    logic en_c, en_d;
    logic [MW+1:0] sum_x, sum_y;
    q_t   x_sat, y_sat;

    assign en_d     = !d_valid_reg || point.ready;
    assign en_c     = !c_valid_reg || en_d;
    assign wt_ready = en_c;

    assign c_valid_next = en_c ? wt_valid : c_valid_reg;
    assign d_valid_next = en_d ? c_valid_reg : d_valid_reg;

    always_comb
    begin
        sum_x = {2'b00, c_x1_reg} + {2'b00, c_x2_reg} + {{(MW+2-W){1'b0}}, c_w3_reg};
        sum_y = {2'b00, c_y1_reg} + {2'b00, c_y2_reg} + {{(MW+2-W){1'b0}}, c_w3_reg};
        x_sat = (sum_x > {{(MW+2-W){1'b0}}, ONE}) ? ONE : sum_x[W-1:0];
        y_sat = (sum_y > {{(MW+2-W){1'b0}}, ONE}) ? ONE : sum_y[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_x1_reg <= qmul({2'b00, cp.p1x}, wt.w1);
            c_x2_reg <= qmul({2'b00, cp.p2x}, wt.w2);
            c_y1_reg <= qmul({2'b00, cp.p1y}, wt.w1);
            c_y2_reg <= qmul({2'b00, cp.p2y}, wt.w2);
            c_w3_reg <= wt.w3;
        end
        if (en_d)
        begin
            d_x_reg <= x_sat;
            d_y_reg <= fade_out ? q_t'(ONE - y_sat) : y_sat;
        end
    end

    assign point.valid   = d_valid_reg;
    assign point.point_x = d_x_reg;
    assign point.point_y = d_y_reg;

endmodule

/* src/fade_curve_bezier_point_unit.sv */
// Fade curve Bezier point unit: cubic Bezier envelope point for each t.
// Four register stages: a request taken at the input passes through the weight stages
// and the blend stages before its point is output. Throughput is one request per cycle
// when the output is not stalled; each stage holds at most one rounded multiply of up to
// 17x19 bits in depth, and stalls back up stage by stage without losing a request.
// Reset clears all pipeline valid bits and loads the default configuration
// (bend 0, strength 0.5, long mode, fade in).
module fade_curve_bezier_point_unit import fcb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  q_t        cfg_data,
    fcb_in_if.sink    param,
    fcb_out_if.source point
);

    // Configuration registers. Writes saturate the factors to one and an
    // unused curve mode code to the long mode.
    q_t          bend_reg, bend_next;
    q_t          strength_reg, strength_next;
    curve_mode_t mode_reg, mode_next;
    logic        fade_out_reg, fade_out_next;

    cfg_t     cfg;
    cpoints_t cp;
    weights_t wt;
    logic     wt_valid, wt_ready;
    q_t       data_sat;

    assign data_sat = (cfg_data > ONE) ? ONE : cfg_data;

    always_comb
    begin
        bend_next     = bend_reg;
        strength_next = strength_reg;
        mode_next     = mode_reg;
        fade_out_next = fade_out_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_BEND:     bend_next     = data_sat;
                REG_STRENGTH: strength_next = data_sat;
                REG_MODE:
                begin
                    if (cfg_data[1:0] inside {MODE_BENDED, MODE_S_SHAPE})
                        mode_next = curve_mode_t'(cfg_data[1:0]);
                    else
                        mode_next = MODE_LONG;
                end
                REG_FADE_OUT: fade_out_next = cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bend_reg     <= '0;
            strength_reg <= ONE >> 1;
            mode_reg     <= MODE_LONG;
            fade_out_reg <= 1'b0;
        end
        else
        begin
            bend_reg     <= bend_next;
            strength_reg <= strength_next;
            mode_reg     <= mode_next;
            fade_out_reg <= fade_out_next;
        end
    end

    assign cfg.bend     = bend_reg;
    assign cfg.strength = strength_reg;
    assign cfg.mode     = mode_reg;
    assign cfg.fade_out = fade_out_reg;

    // The control points only depend on configuration, so they are held
    // beside the pipeline rather than carried with each request.
    fcb_ctrl_points u_ctrl_points
    (
        .clk (clk),
        .cfg (cfg),
        .cp  (cp)
    );

    // Stages one and two: t, 1-t and their products, then the weights.
    fcb_weights u_weights
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .param    (param),
        .wt_valid (wt_valid),
        .wt_ready (wt_ready),
        .wt       (wt)
    );

    // Stages three and four: weighted control points, sum and mirror.
    fcb_blend u_blend
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wt_valid (wt_valid),
        .wt_ready (wt_ready),
        .wt       (wt),
        .cp       (cp),
        .fade_out (fade_out_reg),
        .point    (point)
    );

endmodule
